### rtl/mfba_pkg.sv
// package for the max flow block: sizes, command codes, control/status structs
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none
package mfba_pkg;

	localparam int MAX_NODES = 64;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int CNT_W     = IDX_W + 1;
	localparam int NODE_W    = 7;
	localparam int CAP_W     = 16;
	localparam int CMD_W     = 2;
	localparam int DATA_W    = 32;
	localparam int STATE_W   = 5;

	localparam logic [DATA_W-1:0] AUGMENT_CAP = 32'd2000000000;

	// input command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// residual address selects
	localparam logic [2:0] A_CLR  = 3'd0;
	localparam logic [2:0] A_AB   = 3'd1;
	localparam logic [2:0] A_BA   = 3'd2;
	localparam logic [2:0] A_SCAN = 3'd3;
	localparam logic [2:0] A_PV   = 3'd4;
	localparam logic [2:0] A_UV   = 3'd5;
	localparam logic [2:0] A_VU   = 3'd6;

	// residual write data selects
	localparam logic [1:0] W_ZERO    = 2'd0;
	localparam logic [1:0] W_ADDCAP  = 2'd1;
	localparam logic [1:0] W_SUB     = 2'd2;
	localparam logic [1:0] W_ADDBEST = 2'd3;

	typedef struct packed {
		logic [2:0] asel;
		logic       res_we;
		logic [1:0] wsel;
		logic       clr_start;
		logic       clr_step;
		logic       latch_in;
		logic       flow_zero;
		logic       bfs_init;
		logic       q_rd;
		logic       u_load;
		logic       scan_step;
		logic       walk_init;
		logic       up_init;
		logic       u_from_par;
		logic       best_min;
		logic       v_from_u;
		logic       flow_acc;
		logic       out_load;
	} mfba_cmd_t;

	typedef struct packed {
		logic             clr_done;
		logic             add_ok;
		logic             cmp_ok;
		logic [CMD_W-1:0] cmd;
		logic             q_empty;
		logic             scan_last;
		logic             t_visited;
		logic             v_is_s;
		logic             out_free;
	} mfba_status_t;

	function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
	endfunction

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		return (n != '0) && (32'(n) <= MAX_NODES);
	endfunction

	function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] m;
		m = n - NODE_W'(1);
		return m[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/mfba_ram.sv
// generic ram: one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/mfba_ctrl.sv
// controller state machine: command decode, search, bottleneck walk, update walk
// depends on mfba_pkg
`timescale 1ns / 1ps
`default_nettype none
module mfba_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire mfba_pkg::mfba_status_t st,
	output mfba_pkg::mfba_cmd_t        cmd
);
	import mfba_pkg::*;

	localparam logic [STATE_W-1:0] S_CLR   = 5'd0;
	localparam logic [STATE_W-1:0] S_IDLE  = 5'd1;
	localparam logic [STATE_W-1:0] S_AF_RD = 5'd2;
	localparam logic [STATE_W-1:0] S_AF_WR = 5'd3;
	localparam logic [STATE_W-1:0] S_AR_RD = 5'd4;
	localparam logic [STATE_W-1:0] S_AR_WR = 5'd5;
	localparam logic [STATE_W-1:0] S_BINIT = 5'd6;
	localparam logic [STATE_W-1:0] S_POP   = 5'd7;
	localparam logic [STATE_W-1:0] S_POPW  = 5'd8;
	localparam logic [STATE_W-1:0] S_SCAN  = 5'd9;
	localparam logic [STATE_W-1:0] S_CHK   = 5'd10;
	localparam logic [STATE_W-1:0] S_WINIT = 5'd11;
	localparam logic [STATE_W-1:0] S_WP    = 5'd12;
	localparam logic [STATE_W-1:0] S_WPW   = 5'd13;
	localparam logic [STATE_W-1:0] S_WRW   = 5'd14;
	localparam logic [STATE_W-1:0] S_UINIT = 5'd15;
	localparam logic [STATE_W-1:0] S_UP    = 5'd16;
	localparam logic [STATE_W-1:0] S_UPW   = 5'd17;
	localparam logic [STATE_W-1:0] S_UW1   = 5'd18;
	localparam logic [STATE_W-1:0] S_UR2   = 5'd19;
	localparam logic [STATE_W-1:0] S_UW2   = 5'd20;
	localparam logic [STATE_W-1:0] S_DONE  = 5'd21;

	logic [STATE_W-1:0] state_q, state_d;

	// state register, reset starts with a clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.asel     = A_CLR;
				cmd.res_we   = 1'b1;
				cmd.wsel     = W_ZERO;
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					case (st.cmd)
						CMD_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d = S_CLR;
						end
						CMD_ADD: begin
							if (st.add_ok) state_d = S_AF_RD;
						end
						CMD_COMPUTE: begin
							cmd.flow_zero = 1'b1;
							state_d = st.cmp_ok ? S_BINIT : S_DONE;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_AF_RD: begin
				cmd.asel = A_AB;
				state_d  = S_AF_WR;
			end
			S_AF_WR: begin
				cmd.asel   = A_AB;
				cmd.res_we = 1'b1;
				cmd.wsel   = W_ADDCAP;
				state_d    = S_AR_RD;
			end
			S_AR_RD: begin
				cmd.asel = A_BA;
				state_d  = S_AR_WR;
			end
			S_AR_WR: begin
				cmd.asel   = A_BA;
				cmd.res_we = 1'b1;
				cmd.wsel   = W_ADDCAP;
				state_d    = S_IDLE;
			end
			S_BINIT: begin
				cmd.bfs_init = 1'b1;
				state_d      = S_POP;
			end
			S_POP: begin
				if (st.q_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = S_POPW;
				end
			end
			S_POPW: begin
				cmd.u_load = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				cmd.asel      = A_SCAN;
				cmd.scan_step = 1'b1;
				if (st.scan_last) state_d = S_CHK;
			end
			S_CHK: begin
				state_d = st.t_visited ? S_WINIT : S_POP;
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = S_WP;
			end
			S_WP: begin
				state_d = st.v_is_s ? S_UINIT : S_WPW;
			end
			S_WPW: begin
				cmd.asel       = A_PV;
				cmd.u_from_par = 1'b1;
				state_d        = S_WRW;
			end
			S_WRW: begin
				cmd.best_min = 1'b1;
				cmd.v_from_u = 1'b1;
				state_d      = S_WP;
			end
			S_UINIT: begin
				cmd.up_init = 1'b1;
				state_d     = S_UP;
			end
			S_UP: begin
				if (st.v_is_s) begin
					cmd.flow_acc = 1'b1;
					state_d      = S_BINIT;
				end else begin
					state_d = S_UPW;
				end
			end
			S_UPW: begin
				cmd.asel       = A_PV;
				cmd.u_from_par = 1'b1;
				state_d        = S_UW1;
			end
			S_UW1: begin
				cmd.asel   = A_UV;
				cmd.res_we = 1'b1;
				cmd.wsel   = W_SUB;
				state_d    = S_UR2;
			end
			S_UR2: begin
				cmd.asel = A_VU;
				state_d  = S_UW2;
			end
			S_UW2: begin
				cmd.asel     = A_VU;
				cmd.res_we   = 1'b1;
				cmd.wsel     = W_ADDBEST;
				cmd.v_from_u = 1'b1;
				state_d      = S_UP;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// an item is taken only in idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |-> (state_q == S_IDLE))
		else $error("item taken outside idle");
	// a result is loaded only when the output register is free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over pending result");
	// scan always follows a queue pop
	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) != S_SCAN) |-> $past(state_q) == S_POPW)
		else $error("scan entered without pop");

endmodule
`default_nettype wire

### rtl/mfba_dp.sv
// datapath: residual matrix, queue and parent memories, search and walk registers
// depends on mfba_pkg and mfba_ram
`timescale 1ns / 1ps
`default_nettype none
module mfba_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mfba_pkg::mfba_cmd_t           cmd,
	output mfba_pkg::mfba_status_t             st,
	input  wire logic [mfba_pkg::CMD_W-1:0]    command,
	input  wire logic [mfba_pkg::NODE_W-1:0]   node_a,
	input  wire logic [mfba_pkg::NODE_W-1:0]   node_b,
	input  wire logic [mfba_pkg::CAP_W-1:0]    capacity,
	input  wire logic [mfba_pkg::NODE_W-1:0]   src_node,
	input  wire logic [mfba_pkg::NODE_W-1:0]   snk_node,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic      [mfba_pkg::DATA_W-1:0]   flow_value
);
	import mfba_pkg::*;

	logic [IDX_W-1:0]     a_q, b_q, u_q, v_q, s_idx, t_idx, v_s1;
	logic [CAP_W-1:0]     cap_q;
	logic [ADDR_W-1:0]    clr_cnt_q, res_addr;
	logic [CNT_W-1:0]     head_q, tail_q, scan_cnt_q;
	logic                 vld_s1, discover, out_valid_q;
	logic [MAX_NODES-1:0] vis_q;
	logic [DATA_W-1:0]    best_q, flow_q, out_q, res_rdata, res_wdata;
	logic [IDX_W-1:0]     q_rdata, par_rdata, q_waddr, q_wdata;

	assign s_idx = node_idx(src_node);
	assign t_idx = node_idx(snk_node);

	// residual address select
	always_comb begin
		case (cmd.asel)
			A_CLR:   res_addr = clr_cnt_q;
			A_AB:    res_addr = {a_q, b_q};
			A_BA:    res_addr = {b_q, a_q};
			A_SCAN:  res_addr = {u_q, scan_cnt_q[IDX_W-1:0]};
			A_PV:    res_addr = {par_rdata, v_q};
			A_UV:    res_addr = {u_q, v_q};
			A_VU:    res_addr = {v_q, u_q};
			default: res_addr = clr_cnt_q;
		endcase
	end

	// residual write data select
	always_comb begin
		case (cmd.wsel)
			W_ZERO:    res_wdata = '0;
			W_ADDCAP:  res_wdata = add_sat(res_rdata, DATA_W'(cap_q));
			W_SUB:     res_wdata = res_rdata - best_q;
			W_ADDBEST: res_wdata = add_sat(res_rdata, best_q);
			default:   res_wdata = '0;
		endcase
	end

	mfba_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NODES * MAX_NODES)) u_res (
		.clk   (clk),
		.we    (cmd.res_we),
		.waddr (res_addr),
		.wdata (res_wdata),
		.raddr (res_addr),
		.rdata (res_rdata)
	);

	// newly reached neighbor of the node being scanned
	assign discover = vld_s1 && (res_rdata != '0) && !vis_q[v_s1];

	assign q_waddr = cmd.bfs_init ? '0 : tail_q[IDX_W-1:0];
	assign q_wdata = cmd.bfs_init ? s_idx : v_s1;

	mfba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_queue (
		.clk   (clk),
		.we    (cmd.bfs_init || discover),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (q_rdata)
	);

	mfba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_parent (
		.clk   (clk),
		.we    (discover),
		.waddr (v_s1),
		.wdata (u_q),
		.raddr (v_q),
		.rdata (par_rdata)
	);

	// control registers: clear sweep, queue pointers, scan counter, visited marks, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			scan_cnt_q  <= '0;
			vld_s1      <= 1'b0;
			vis_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				clr_cnt_q <= '0;
			end else if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (cmd.bfs_init) begin
				head_q <= '0;
				tail_q <= CNT_W'(1);
				vis_q  <= MAX_NODES'(1) << s_idx;
			end else begin
				if (cmd.q_rd) head_q <= head_q + CNT_W'(1);
				if (discover) begin
					tail_q      <= tail_q + CNT_W'(1);
					vis_q[v_s1] <= 1'b1;
				end
			end
			if (cmd.u_load) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			vld_s1 <= cmd.scan_step && (32'(scan_cnt_q) < MAX_NODES);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			a_q   <= node_idx(node_a);
			b_q   <= node_idx(node_b);
			cap_q <= capacity;
		end
		v_s1 <= scan_cnt_q[IDX_W-1:0];
		if (cmd.u_load) begin
			u_q <= q_rdata;
		end else if (cmd.u_from_par) begin
			u_q <= par_rdata;
		end
		if (cmd.walk_init || cmd.up_init) begin
			v_q <= t_idx;
		end else if (cmd.v_from_u) begin
			v_q <= u_q;
		end
		if (cmd.walk_init) begin
			best_q <= AUGMENT_CAP;
		end else if (cmd.best_min && res_rdata < best_q) begin
			best_q <= res_rdata;
		end
		if (cmd.flow_zero) begin
			flow_q <= '0;
		end else if (cmd.flow_acc) begin
			flow_q <= add_sat(flow_q, best_q);
		end
		if (cmd.out_load) out_q <= flow_q;
	end

	assign out_valid  = out_valid_q;
	assign flow_value = out_q;

	// status to the controller
	always_comb begin
		st.clr_done  = (clr_cnt_q == {ADDR_W{1'b1}});
		st.add_ok    = node_ok(node_a) && node_ok(node_b);
		st.cmp_ok    = node_ok(src_node) && node_ok(snk_node) && (src_node != snk_node);
		st.cmd       = command;
		st.q_empty   = (head_q == tail_q);
		st.scan_last = (32'(scan_cnt_q) == MAX_NODES);
		st.t_visited = vis_q[t_idx];
		st.v_is_s    = (v_q == s_idx);
		st.out_free  = !out_valid_q || !out_stall;
	end

	// queue never holds more items than there are nodes
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tail_q) <= MAX_NODES)
		else $error("queue overflow");
	// an augmenting path always moves a nonzero amount
	a_best_nz: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flow_acc |-> (best_q != '0))
		else $error("zero augmentation");
	// the source is marked visited right after a search starts
	a_src_vis: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bfs_init |=> vis_q[$past(s_idx)])
		else $error("source not marked");

endmodule
`default_nettype wire

### rtl/max_flow_bfs_augment.sv
// top level of the edmonds-karp max flow block: config registers and wiring
// depends on mfba_pkg, mfba_ctrl, mfba_dp, mfba_ram
//
//  channel  | handshake                 | payload
//  input    | in_valid / in_stall       | command, node_a, node_b, capacity
//  output   | out_valid / out_stall     | flow_value
//  config   | apb psel/penable/pwrite   | paddr 0 source_node, 4 sink_node
//
// clear sweeps all 4096 entries of the residual matrix, one entry a cycle
// reset starts the same sweep; items wait until it ends
// add edge does two read-modify-writes through the one shared matrix address
// compute searches breadth first, scanning the matrix row of each dequeued node, then walks
// the path for its bottleneck, then updates it, per augmenting path; one result per compute
// a result waiting under out_stall holds only the end of the next compute
`timescale 1ns / 1ps
`default_nettype none
module max_flow_bfs_augment (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mfba_pkg::CMD_W-1:0]    command,
	input  wire logic [mfba_pkg::NODE_W-1:0]   node_a,
	input  wire logic [mfba_pkg::NODE_W-1:0]   node_b,
	input  wire logic [mfba_pkg::CAP_W-1:0]    capacity,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [mfba_pkg::DATA_W-1:0]   flow_value,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import mfba_pkg::*;

	logic [NODE_W-1:0] src_q, snk_q;
	mfba_cmd_t         cmd;
	mfba_status_t      st;

	assign pready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= NODE_W'(1);
			snk_q <= NODE_W'(2);
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				snk_q <= pwdata[NODE_W-1:0];
			end else begin
				src_q <= pwdata[NODE_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? 32'(snk_q) : 32'(src_q);

	mfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	mfba_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.command    (command),
		.node_a     (node_a),
		.node_b     (node_b),
		.capacity   (capacity),
		.src_node   (src_q),
		.snk_node   (snk_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.flow_value (flow_value)
	);

endmodule
`default_nettype wire
